[sv/ffpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the first-fit page allocator.
// No dependencies; used by ffpa_eval, the top level and the testbench.
package ffpa_pkg;

  localparam int MAX_RUNS = 64;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int PAGE_W   = 16;
  localparam int LEN_W    = 17;
  localparam int ENTRY_W  = PAGE_W + LEN_W;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PAGE_W-1:0] base_page;
    logic [LEN_W-1:0]  page_count;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] alloc_page;
    logic [LEN_W-1:0]  free_pages;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // per-entry verdict of the scan unit
  typedef struct packed {
    logic              keep;
    entry_t            wr;
    logic              hit;
    logic [PAGE_W-1:0] ms;
    logic [LEN_W-1:0]  ml;
  } eval_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

[sv/ffpa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ffpa_eval.sv]
`timescale 1ns / 1ps
// Shared per-entry unit: fit test and front shrink for allocate,
// adjacency test and merge for free. Uses ffpa_pkg.
module ffpa_eval (
  input  logic [1:0]                  kind,
  input  logic                        found,
  input  logic [ffpa_pkg::LEN_W-1:0]  cnt,
  input  logic [ffpa_pkg::PAGE_W-1:0] ms,
  input  logic [ffpa_pkg::LEN_W-1:0]  ml,
  input  ffpa_pkg::entry_t            ent,
  output ffpa_pkg::eval_t             res
);

  logic [ffpa_pkg::LEN_W:0] end_m;
  logic [ffpa_pkg::LEN_W:0] end_e;
  logic [ffpa_pkg::LEN_W-1:0] ml_sum;

  always_comb begin
    end_m  = {2'b00, ms} + {1'b0, ml};
    end_e  = {2'b00, ent.start} + {1'b0, ent.len};
    ml_sum = ffpa_pkg::sat_add(ml, ent.len);
    res.keep = 1'b1;
    res.wr   = ent;
    res.hit  = 1'b0;
    res.ms   = ms;
    res.ml   = ml;
    if (kind == ffpa_pkg::KIND_ALLOC) begin
      if (!found && (ent.len >= cnt)) begin
        res.hit      = 1'b1;
        res.keep     = (ent.len != cnt);
        res.wr.start = ent.start + cnt[ffpa_pkg::PAGE_W-1:0];
        res.wr.len   = ent.len - cnt;
      end
    end else if (kind == ffpa_pkg::KIND_FREE) begin
      if (end_m == {2'b00, ent.start}) begin
        res.keep = 1'b0;
        res.ml   = ml_sum;
      end else if (end_e == {2'b00, ms}) begin
        res.keep = 1'b0;
        res.ml   = ml_sum;
        res.ms   = ent.start;
      end
    end
  end

endmodule

[sv/first_fit_page_allocator.sv]
`timescale 1ns / 1ps
// First-fit page allocator top level: sequencer, run table RAM and totals.
// Uses ffpa_pkg, ffpa_ram and ffpa_eval.
//
// Usage:
//   Drive in_item and raise start; the transaction is taken at a rising edge
//   where start is high and busy is low. busy stays high until the result
//   has been produced. Each transaction gives exactly one result, shown on
//   out_item for one cycle with out_strobe high; the receiver cannot stall.
//   Allocate and free stream the run table through the compare/merge unit
//   one entry per cycle behind the registered RAM read, and write survivors
//   back compacted in the same pass. Add-region, an allocate larger than the
//   free total, an unknown kind and any transaction on an empty table skip
//   the scan and go straight to the result.
//   A new transaction can be taken in the cycle the result is shown.
//   Throughput is set by the single table read port feeding the shared
//   evaluation unit.
//   Reset (rst_n low, synchronous) empties the table and zeroes the free
//   total; table contents need no clearing.
module first_fit_page_allocator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ffpa_pkg::in_t    in_item,
  output logic             out_strobe,
  output ffpa_pkg::out_t   out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [1:0]                    kind_r, kind_nxt;
  logic [ffpa_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [ffpa_pkg::PAGE_W-1:0]   ms_r, ms_nxt;
  logic [ffpa_pkg::LEN_W-1:0]    ml_r, ml_nxt;
  logic [ffpa_pkg::CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [ffpa_pkg::CNT_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic                          pv_r, pv_nxt;
  logic                          found_r, found_nxt;
  logic [ffpa_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [ffpa_pkg::CNT_W-1:0]    run_count_r, run_count_nxt;
  logic [ffpa_pkg::LEN_W-1:0]    free_total_r, free_total_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  ffpa_pkg::out_t                out_r, out_nxt;

  logic                          ram_we;
  logic [ffpa_pkg::IDX_W-1:0]    ram_waddr;
  ffpa_pkg::entry_t              ram_wdata;
  ffpa_pkg::entry_t              ram_rdata;
  ffpa_pkg::eval_t               ev;
  logic                          issue;
  logic                          table_full;

  ffpa_ram #(
    .WIDTH(ffpa_pkg::ENTRY_W),
    .DEPTH(ffpa_pkg::MAX_RUNS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx_r[ffpa_pkg::IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  ffpa_eval u_eval (
    .kind (kind_r),
    .found(found_r),
    .cnt  (cnt_r),
    .ms   (ms_r),
    .ml   (ml_r),
    .ent  (ram_rdata),
    .res  (ev)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;
  assign table_full = (run_count_r >= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_RUNS));
  assign issue      = (state_r == S_SCAN) && (rd_idx_r < run_count_r);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    cnt_nxt        = cnt_r;
    ms_nxt         = ms_r;
    ml_nxt         = ml_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    pv_nxt         = 1'b0;
    found_nxt      = found_r;
    page_nxt       = page_r;
    run_count_nxt  = run_count_r;
    free_total_nxt = free_total_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = wr_idx_r[ffpa_pkg::IDX_W-1:0];
    ram_wdata      = ev.wr;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt   = in_item.kind;
          cnt_nxt    = in_item.page_count;
          ms_nxt     = in_item.base_page;
          ml_nxt     = in_item.page_count;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          found_nxt  = 1'b0;
          page_nxt   = '0;
          state_nxt  = S_FIN;
          if ((run_count_r != '0) &&
              (((in_item.kind == ffpa_pkg::KIND_ALLOC) &&
                (in_item.page_count <= free_total_r)) ||
               (in_item.kind == ffpa_pkg::KIND_FREE))) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + ffpa_pkg::CNT_W'(1);
        end
        pv_nxt = issue;
        if (pv_r) begin
          ms_nxt = ev.ms;
          ml_nxt = ev.ml;
          if (ev.keep) begin
            ram_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + ffpa_pkg::CNT_W'(1);
          end
          if (ev.hit) begin
            found_nxt = 1'b1;
            page_nxt  = ram_rdata.start;
          end
        end
        if (!issue && !pv_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_nxt.status     = ffpa_pkg::ST_NOFIT;
        out_nxt.alloc_page = '0;
        case (kind_r)
          ffpa_pkg::KIND_ADD: begin
            if (table_full) begin
              out_nxt.status = ffpa_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = run_count_r[ffpa_pkg::IDX_W-1:0];
              ram_wdata      = '{start: ms_r, len: cnt_r};
              run_count_nxt  = run_count_r + ffpa_pkg::CNT_W'(1);
              free_total_nxt = ffpa_pkg::sat_add(free_total_r, cnt_r);
              out_nxt.status = ffpa_pkg::ST_OK;
            end
          end
          ffpa_pkg::KIND_ALLOC: begin
            if (found_r) begin
              run_count_nxt      = wr_idx_r;
              free_total_nxt     = free_total_r - cnt_r;
              out_nxt.status     = ffpa_pkg::ST_OK;
              out_nxt.alloc_page = page_r;
            end
          end
          ffpa_pkg::KIND_FREE: begin
            if (wr_idx_r >= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_RUNS)) begin
              out_nxt.status = ffpa_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = '{start: ms_r, len: ml_r};
              run_count_nxt  = wr_idx_r + ffpa_pkg::CNT_W'(1);
              free_total_nxt = ffpa_pkg::sat_add(free_total_r, cnt_r);
              out_nxt.status = ffpa_pkg::ST_OK;
            end
          end
          default: begin
          end
        endcase
        out_nxt.free_pages = free_total_nxt;
        out_strobe_nxt     = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      run_count_r  <= '0;
      free_total_r <= '0;
      out_strobe_r <= 1'b0;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      pv_r         <= pv_nxt;
      found_r      <= found_nxt;
      run_count_r  <= run_count_nxt;
      free_total_r <= free_total_nxt;
      out_strobe_r <= out_strobe_nxt;
      rd_idx_r     <= rd_idx_nxt;
      wr_idx_r     <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    cnt_r  <= cnt_nxt;
    ms_r   <= ms_nxt;
    ml_r   <= ml_nxt;
    page_r <= page_nxt;
    out_r  <= out_nxt;
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_page_allocator: directed corner cases, then random
// alloc/free traffic with full-table episodes. Depends on ffpa_pkg and the block's RTL only.
module tb_top;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned PAGES_MAX   = 131071;

  typedef struct {
    bit [ffpa_pkg::PAGE_W-1:0] first;
    bit [ffpa_pkg::LEN_W-1:0]  pages;
  } run_t;

  class page_alloc_scoreboard;
    run_t             runs[$];
    int unsigned      pool_total = 0;
    ffpa_pkg::out_t   awaited_results[$];
    int unsigned      n_requests = 0;
    int unsigned      n_checked  = 0;
    int unsigned      n_errors   = 0;
    int unsigned      n_status[3] = '{0, 0, 0};

    function int unsigned sat_pages(int unsigned a, int unsigned b);
      return (a + b > PAGES_MAX) ? PAGES_MAX : a + b;
    endfunction

    // Updates the run table for one accepted transaction and queues its result.
    function ffpa_pkg::out_t note_request(ffpa_pkg::in_t req);
      ffpa_pkg::out_t res;
      run_t           kept[$];
      run_t           r;
      int unsigned    ms;
      int unsigned    ml;
      int unsigned    cnt;
      int             hit;
      cnt        = {15'd0, req.page_count};
      res        = '0;
      res.status = ffpa_pkg::ST_NOFIT;
      case (req.kind)
        ffpa_pkg::KIND_ADD: begin
          if (runs.size() >= ffpa_pkg::MAX_RUNS) begin
            res.status = ffpa_pkg::ST_FULL;
          end else begin
            r.first = req.base_page;
            r.pages = req.page_count;
            runs.push_back(r);
            pool_total = sat_pages(pool_total, cnt);
            res.status = ffpa_pkg::ST_OK;
          end
        end
        ffpa_pkg::KIND_ALLOC: begin
          hit = -1;
          if (cnt <= pool_total) begin
            foreach (runs[i]) if (hit < 0 && runs[i].pages >= cnt) hit = i;
          end
          if (hit >= 0) begin
            res.alloc_page = runs[hit].first;
            if (runs[hit].pages > cnt) begin
              // wraps at 16 bits
              runs[hit].first = ffpa_pkg::PAGE_W'(runs[hit].first + cnt);
              runs[hit].pages = ffpa_pkg::LEN_W'(runs[hit].pages - cnt);
            end else begin
              runs.delete(hit);
            end
            pool_total -= cnt;
            res.status = ffpa_pkg::ST_OK;
          end
        end
        ffpa_pkg::KIND_FREE: begin
          ms = {16'd0, req.base_page};
          ml = cnt;
          // one pass in table order; entries already passed are not revisited
          foreach (runs[i]) begin
            if (ms + ml == runs[i].first) begin
              ml = sat_pages(ml, runs[i].pages);
            end else if (runs[i].first + runs[i].pages == ms) begin
              ml = sat_pages(ml, runs[i].pages);
              ms = runs[i].first;
            end else begin
              kept.push_back(runs[i]);
            end
          end
          if (kept.size() >= ffpa_pkg::MAX_RUNS) begin
            res.status = ffpa_pkg::ST_FULL;
          end else begin
            r.first = ffpa_pkg::PAGE_W'(ms);
            r.pages = ffpa_pkg::LEN_W'(ml);
            kept.push_back(r);
            runs       = kept;
            pool_total = sat_pages(pool_total, cnt);
            res.status = ffpa_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      res.free_pages = ffpa_pkg::LEN_W'(pool_total);
      awaited_results.push_back(res);
      n_requests++;
      return res;
    endfunction

    function void check_result(ffpa_pkg::out_t got);
      ffpa_pkg::out_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, alloc_page %0d, free_pages %0d",
               got.status, got.alloc_page, got.free_pages);
        n_errors++;
        return;
      end
      want = awaited_results.pop_front();
      n_checked++;
      n_status[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
      if (got.alloc_page !== want.alloc_page) begin
        $error("alloc_page: expected %0d, got %0d", want.alloc_page, got.alloc_page);
        n_errors++;
      end
      if (got.free_pages !== want.free_pages) begin
        $error("free_pages: expected %0d, got %0d", want.free_pages, got.free_pages);
        n_errors++;
      end
    endfunction
  endclass

  logic           clk     = 1'b0;
  logic           rst_n   = 1'b0;
  logic           start   = 1'b0;
  ffpa_pkg::in_t  in_item = '0;
  logic           busy;
  logic           out_strobe;
  ffpa_pkg::out_t out_item;

  page_alloc_scoreboard sb;
  run_t                 held_blocks[$];
  bit                   steady = 1'b0;

  first_fit_page_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // start idles at random in about a third of the cycles unless steady is set
  task automatic drive_request(input ffpa_pkg::in_t req, output ffpa_pkg::out_t pred);
    bit go;
    go = 1'b0;
    in_item <= req;
    while (!go) begin
      go = steady || ($urandom_range(99) >= 34);
      start <= go;
      @(posedge clk);
      go = go && !busy;
    end
    pred = sb.note_request(req);
  endtask

  task automatic issue(input logic [1:0] kind, input int unsigned base,
                       input int unsigned cnt);
    ffpa_pkg::in_t  req;
    ffpa_pkg::out_t pred;
    run_t           blk;
    req.kind       = kind;
    req.base_page  = base[ffpa_pkg::PAGE_W-1:0];
    req.page_count = cnt[ffpa_pkg::LEN_W-1:0];
    drive_request(req, pred);
    if (kind == ffpa_pkg::KIND_ALLOC && pred.status == ffpa_pkg::ST_OK && cnt != 0) begin
      blk.first = pred.alloc_page;
      blk.pages = cnt[ffpa_pkg::LEN_W-1:0];
      held_blocks.push_back(blk);
    end
  endtask

  task automatic free_held();
    int unsigned k;
    run_t        blk;
    if (held_blocks.size() == 0) begin
      issue(ffpa_pkg::KIND_ADD, $urandom_range(65535), $urandom_range(1, 256));
    end else begin
      k   = $urandom_range(held_blocks.size() - 1);
      blk = held_blocks[k];
      held_blocks.delete(k);
      issue(ffpa_pkg::KIND_FREE, blk.first, blk.pages);
    end
  endtask

  // Fill the table, hit the full cases, then drain it down to 24 runs with exact-fit allocations.
  task automatic fill_run_table();
    int unsigned guard;
    run_t        last;
    guard = 0;
    while (sb.runs.size() < ffpa_pkg::MAX_RUNS && guard < 80) begin
      issue(ffpa_pkg::KIND_ADD, $urandom_range(65535), $urandom_range(1, 8));
      guard++;
    end
    issue(ffpa_pkg::KIND_ADD, $urandom_range(65535), $urandom_range(1, 8));
    if (sb.runs.size() == ffpa_pkg::MAX_RUNS) begin
      last = sb.runs[ffpa_pkg::MAX_RUNS-1];
      issue(ffpa_pkg::KIND_FREE, last.first + last.pages, $urandom_range(1, 4));
    end
    issue(ffpa_pkg::KIND_FREE, $urandom_range(65535), $urandom_range(1, 8));
    free_held();
    guard = 0;
    while (sb.runs.size() > 24 && guard < 60) begin
      issue(ffpa_pkg::KIND_ALLOC, $urandom_range(65535), sb.runs[0].pages);
      guard++;
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned cnt;
    int unsigned waited;
    logic [1:0]  kind;
    sb = new;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    issue(ffpa_pkg::KIND_ALLOC, 0, 5);
    issue(KIND_UNUSED, 16'hFFFF, 17'h1FFFF);
    issue(ffpa_pkg::KIND_ADD, 65535, 131071);
    issue(ffpa_pkg::KIND_ADD, 7, 1);
    issue(ffpa_pkg::KIND_ALLOC, 0, 131071);
    issue(ffpa_pkg::KIND_ALLOC, 0, 1);
    issue(ffpa_pkg::KIND_FREE, 8, 1);
    issue(ffpa_pkg::KIND_ADD, 100, 10);
    issue(ffpa_pkg::KIND_ADD, 0, 0);
    issue(ffpa_pkg::KIND_ALLOC, 0, 0);
    issue(ffpa_pkg::KIND_ALLOC, 0, 3);
    issue(ffpa_pkg::KIND_ALLOC, 0, 2);
    issue(ffpa_pkg::KIND_ADD, 65530, 20);
    issue(ffpa_pkg::KIND_ALLOC, 0, 25);
    issue(ffpa_pkg::KIND_ALLOC, 0, 10);
    issue(ffpa_pkg::KIND_FREE, 65535, 1);
    issue(ffpa_pkg::KIND_FREE, 0, 4);
    issue(ffpa_pkg::KIND_ADD, 98, 5);
    issue(ffpa_pkg::KIND_FREE, 110, 5);
    issue(ffpa_pkg::KIND_FREE, 115, 10);
    issue(ffpa_pkg::KIND_FREE, 0, 0);
    issue(ffpa_pkg::KIND_ALLOC, 16'hFFFF, 131071);
    issue(ffpa_pkg::KIND_ADD, 40000, 65536);
    issue(ffpa_pkg::KIND_ALLOC, 0, 65536);
    issue(KIND_UNUSED, 0, 0);
    held_blocks.delete();

    for (int n = 0; n < 200; n++) begin
      steady = (n >= 60 && n < 100);
      if (n == 40 || n == 110 || n == 170) fill_run_table();
      pick = $urandom_range(99);
      if (pick < 30) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        if ($urandom_range(24) == 0) cnt = 0;
        issue(ffpa_pkg::KIND_ALLOC, $urandom_range(65535), cnt);
      end else if (pick < 55) begin
        free_held();
      end else if (pick < 70) begin
        issue(ffpa_pkg::KIND_ADD, $urandom_range(65535), $urandom_range(1, 256));
      end else if (pick < 80 && sb.runs.size() != 0) begin
        issue(ffpa_pkg::KIND_ALLOC, $urandom_range(65535),
              sb.runs[$urandom_range(sb.runs.size() - 1)].pages);
      end else if (pick < 90) begin
        issue(ffpa_pkg::KIND_FREE, $urandom_range(65535), $urandom_range(0, 64));
      end else begin
        kind = 2'($urandom_range(3));
        cnt  = (kind == ffpa_pkg::KIND_ADD) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 131071);
        issue(kind, $urandom_range(65535), cnt);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (sb.awaited_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (sb.awaited_results.size() != 0) begin
      $error("%0d results never arrived", sb.awaited_results.size());
      sb.n_errors++;
    end

    $display("Sent %0d transactions incl. three full-table episodes; checked %0d results",
             sb.n_requests, sb.n_checked);
    $display("  status ok %0d, no fit %0d, table full %0d; %0d mismatches",
             sb.n_status[ffpa_pkg::ST_OK], sb.n_status[ffpa_pkg::ST_NOFIT],
             sb.n_status[ffpa_pkg::ST_FULL], sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[first_fit_page_allocator.f]
sv/ffpa_pkg.sv
sv/ffpa_ram.sv
sv/ffpa_eval.sv
sv/first_fit_page_allocator.sv
verif/tb_top.sv
